@@ design/dtli_pkg.sv @@
package dtli_pkg;

	localparam int NODE_CAP_DEF   = 4096;
	localparam int LEVELS_DEF     = 8;
	localparam int VALUE_BITS_DEF = 32;

	localparam int FANOUT     = 10;
	localparam int ROOTS      = 10;
	localparam int KEY_DIGITS = 9;
	localparam int KEY_W      = 4 * KEY_DIGITS;
	localparam int VAL_W      = 32;
	localparam int STAT_W     = 2;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADKEY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_WRITE,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RK_MISS,
		RK_HIT,
		RK_UPD,
		RK_FULL,
		RK_BAD
	} res_kind_t;

	typedef struct packed {
		logic      clr;
		logic      load;
		logic      start;
		logic      rd;
		logic      descend;
		logic      mark_found;
		logic      wr;
		logic      fin;
		res_kind_t kind;
	} dtli_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic digits_ok;
		logic upd;
		logic last;
		logic slot_zero;
		logic slot_empty;
		logic room_ok;
		logic out_free;
	} dtli_sts_t;

endpackage

@@ design/dtli_req_if.sv @@
interface dtli_req_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [dtli_pkg::KEY_W-1:0] key_digits;
	logic [dtli_pkg::VAL_W-1:0] value;

	modport source (output valid, output command, output key_digits, output value,
		input ready);
	modport sink (input valid, input command, input key_digits, input value,
		output ready);
endinterface

@@ design/dtli_rsp_if.sv @@
interface dtli_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [dtli_pkg::STAT_W-1:0] status;
	logic                        found;
	logic [dtli_pkg::VAL_W-1:0]  value_out;

	modport source (output valid, output status, output found, output value_out,
		input ready);
	modport sink (input valid, input status, input found, input value_out,
		output ready);
endinterface

@@ design/decimal_trie_lookup_insert_top.sv @@
// channel  dir  interface    words
// req      in   dtli_req_if  command, key_digits, value
// rsp      out  dtli_rsp_if  status, found, value_out
//
// One word at a time; all node accesses go through the single node memory port.
// Search: one read (S_READ) and one decision (S_EVAL) per level.
// Update: search walk plus one write per level from the first missing slot to the leaf.
// After reset all NODE_CAP*10 slots (40960) of the node memory are swept to zero; req is not ready.
// The next word is taken while a result waits on rsp; a stalled rsp holds completion.
module decimal_trie_lookup_insert_top #(
	parameter int NODE_CAP   = dtli_pkg::NODE_CAP_DEF,
	parameter int LEVELS     = dtli_pkg::LEVELS_DEF,
	parameter int VALUE_BITS = dtli_pkg::VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dtli_req_if.sink  req,
	dtli_rsp_if.source rsp
);

	dtli_pkg::dtli_cmd_t cmd;
	dtli_pkg::dtli_sts_t sts;

	dtli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtli_dp #(
		.NODE_CAP   (NODE_CAP),
		.LEVELS     (LEVELS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_command    (req.command),
		.in_key_digits (req.key_digits),
		.in_value      (req.value),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_found     (rsp.found),
		.out_value_out (rsp.value_out)
	);

endmodule

@@ design/dtli_ctrl.sv @@
module dtli_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dtli_pkg::dtli_sts_t sts,
	output dtli_pkg::dtli_cmd_t cmd
);

	dtli_pkg::state_t    state_q, state_d;
	dtli_pkg::res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtli_pkg::S_CLEAR;
			kind_q  <= dtli_pkg::RK_MISS;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			dtli_pkg::S_CLEAR: begin
				if (sts.clr_last)
					state_d = dtli_pkg::S_IDLE;
			end
			dtli_pkg::S_IDLE: begin
				if (in_valid)
					state_d = dtli_pkg::S_CHECK;
			end
			dtli_pkg::S_CHECK: begin
				if (!sts.digits_ok) begin
					kind_d  = dtli_pkg::RK_BAD;
					state_d = dtli_pkg::S_DONE;
				end else begin
					state_d = dtli_pkg::S_READ;
				end
			end
			dtli_pkg::S_READ: begin
				state_d = dtli_pkg::S_EVAL;
			end
			dtli_pkg::S_EVAL: begin
				if (sts.last) begin
					if (sts.upd) begin
						kind_d  = dtli_pkg::RK_UPD;
						state_d = dtli_pkg::S_WRITE;
					end else begin
						kind_d  = sts.slot_zero ? dtli_pkg::RK_MISS : dtli_pkg::RK_HIT;
						state_d = dtli_pkg::S_DONE;
					end
				end else if (!sts.slot_empty) begin
					state_d = dtli_pkg::S_READ;
				end else if (!sts.upd) begin
					kind_d  = dtli_pkg::RK_MISS;
					state_d = dtli_pkg::S_DONE;
				end else if (!sts.room_ok) begin
					kind_d  = dtli_pkg::RK_FULL;
					state_d = dtli_pkg::S_DONE;
				end else begin
					kind_d  = dtli_pkg::RK_UPD;
					state_d = dtli_pkg::S_WRITE;
				end
			end
			dtli_pkg::S_WRITE: begin
				if (sts.last)
					state_d = dtli_pkg::S_DONE;
			end
			dtli_pkg::S_DONE: begin
				if (sts.out_free)
					state_d = dtli_pkg::S_IDLE;
			end
			default: begin
				state_d = dtli_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = kind_q;
		in_ready = 1'b0;
		unique case (state_q)
			dtli_pkg::S_CLEAR: cmd.clr = 1'b1;
			dtli_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			dtli_pkg::S_CHECK: cmd.start = 1'b1;
			dtli_pkg::S_READ:  cmd.rd = 1'b1;
			dtli_pkg::S_EVAL: begin
				if (sts.last)
					cmd.mark_found = sts.upd;
				else
					cmd.descend = !sts.slot_empty;
			end
			dtli_pkg::S_WRITE: cmd.wr = 1'b1;
			dtli_pkg::S_DONE:  cmd.fin = sts.out_free;
			default: cmd.fin = 1'b0;
		endcase
	end

endmodule

@@ design/dtli_dp.sv @@
module dtli_dp #(
	parameter int NODE_CAP   = dtli_pkg::NODE_CAP_DEF,
	parameter int LEVELS     = dtli_pkg::LEVELS_DEF,
	parameter int VALUE_BITS = dtli_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dtli_pkg::dtli_cmd_t          cmd,
	output dtli_pkg::dtli_sts_t          sts,
	input  logic                         in_command,
	input  logic [dtli_pkg::KEY_W-1:0]   in_key_digits,
	input  logic [dtli_pkg::VAL_W-1:0]   in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dtli_pkg::STAT_W-1:0]  out_status,
	output logic                         out_found,
	output logic [dtli_pkg::VAL_W-1:0]   out_value_out
);

	localparam int NodeBits   = $clog2(NODE_CAP);
	localparam int FreeBits   = $clog2(NODE_CAP + 1);
	localparam int Slots      = NODE_CAP * dtli_pkg::FANOUT;
	localparam int AddrBits   = $clog2(Slots);
	localparam int StoredBits = (VALUE_BITS < dtli_pkg::VAL_W) ? VALUE_BITS : dtli_pkg::VAL_W;
	localparam int SlotBits   = (StoredBits > NodeBits) ? StoredBits : NodeBits;
	localparam int LvlBits    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PosBits    = $clog2(LEVELS + 1);
	localparam logic [SlotBits:0] CapL = (SlotBits + 1)'(NODE_CAP);

	logic [SlotBits-1:0] mem [Slots];

	logic                       upd_q;
	logic [dtli_pkg::KEY_W-1:0] key_q;
	logic [StoredBits-1:0]      val_q;
	logic [NodeBits-1:0]        node_q;
	logic [LvlBits-1:0]         level_q;
	logic [FreeBits-1:0]        next_free_q;
	logic [FreeBits-1:0]        alloc_q;
	logic                       found_q;
	logic [AddrBits-1:0]        clr_cnt_q;
	logic [SlotBits-1:0]        rdata_q;
	logic                       out_valid_q;
	logic [dtli_pkg::STAT_W-1:0] out_status_q;
	logic                       out_found_q;
	logic [dtli_pkg::VAL_W-1:0] out_value_q;

	logic [3:0]                 dig_a [LEVELS+1];
	logic                       digits_ok;
	logic [PosBits-1:0]         pos;
	logic [3:0]                 cur_dig;
	logic [AddrBits-1:0]        slot_addr;
	logic [AddrBits-1:0]        mem_addr;
	logic                       mem_we;
	logic [SlotBits-1:0]        mem_wdata;
	logic                       last;
	logic                       slot_zero;
	logic [FreeBits:0]          room_sum;
	logic [SlotBits+dtli_pkg::VAL_W-1:0] hit_ext;

	for (genvar p = 0; p <= LEVELS; p++) begin : g_dig
		if (LEVELS - p < dtli_pkg::KEY_DIGITS) begin : g_in
			assign dig_a[p] = key_q[4*(LEVELS-p) +: 4];
		end else begin : g_out
			assign dig_a[p] = 4'd0;
		end
	end

	always_comb begin
		digits_ok = 1'b1;
		for (int p = 0; p <= LEVELS; p++) begin
			if (dig_a[p] >= 4'(dtli_pkg::FANOUT))
				digits_ok = 1'b0;
		end
	end

	assign pos       = PosBits'(level_q) + PosBits'(1);
	assign cur_dig   = dig_a[pos];
	assign slot_addr = AddrBits'({node_q, 3'b000}) + AddrBits'({node_q, 1'b0})
		+ AddrBits'(cur_dig);
	assign last      = (level_q == LvlBits'(LEVELS - 1));
	assign slot_zero = (rdata_q == '0);
	assign room_sum  = (FreeBits + 1)'(next_free_q) + (FreeBits + 1)'(LEVELS - 1)
		- (FreeBits + 1)'(level_q);
	assign hit_ext   = {dtli_pkg::VAL_W'(0), rdata_q};

	assign mem_addr  = cmd.clr ? clr_cnt_q : slot_addr;
	assign mem_we    = cmd.clr | cmd.wr;
	assign mem_wdata = cmd.clr ? '0 : (last ? SlotBits'(val_q) : SlotBits'(alloc_q));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (cmd.rd)
			rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			next_free_q <= FreeBits'(dtli_pkg::ROOTS);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr)
				clr_cnt_q <= clr_cnt_q + AddrBits'(1);
			if (cmd.wr && last)
				next_free_q <= alloc_q;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			upd_q   <= in_command;
			key_q   <= in_key_digits;
			val_q   <= in_value[StoredBits-1:0];
			alloc_q <= next_free_q;
			found_q <= 1'b0;
		end
		if (cmd.start) begin
			node_q  <= NodeBits'(dig_a[0]);
			level_q <= '0;
		end
		if (cmd.descend) begin
			node_q  <= rdata_q[NodeBits-1:0];
			level_q <= level_q + LvlBits'(1);
		end
		if (cmd.mark_found)
			found_q <= !slot_zero;
		if (cmd.wr && !last) begin
			node_q  <= alloc_q[NodeBits-1:0];
			alloc_q <= alloc_q + FreeBits'(1);
			level_q <= level_q + LvlBits'(1);
		end
		if (cmd.fin) begin
			unique case (cmd.kind)
				dtli_pkg::RK_HIT: begin
					out_status_q <= dtli_pkg::STAT_OK;
					out_found_q  <= 1'b1;
					out_value_q  <= hit_ext[dtli_pkg::VAL_W-1:0];
				end
				dtli_pkg::RK_UPD: begin
					out_status_q <= dtli_pkg::STAT_OK;
					out_found_q  <= found_q;
					out_value_q  <= '0;
				end
				dtli_pkg::RK_FULL: begin
					out_status_q <= dtli_pkg::STAT_FULL;
					out_found_q  <= 1'b0;
					out_value_q  <= '0;
				end
				dtli_pkg::RK_BAD: begin
					out_status_q <= dtli_pkg::STAT_BADKEY;
					out_found_q  <= 1'b0;
					out_value_q  <= '0;
				end
				default: begin
					out_status_q <= dtli_pkg::STAT_OK;
					out_found_q  <= 1'b0;
					out_value_q  <= '0;
				end
			endcase
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_cnt_q == AddrBits'(Slots - 1));
		sts.digits_ok  = digits_ok;
		sts.upd        = upd_q;
		sts.last       = last;
		sts.slot_zero  = slot_zero;
		sts.slot_empty = slot_zero || ({1'b0, rdata_q} >= CapL);
		sts.room_ok    = (room_sum <= (FreeBits + 1)'(NODE_CAP));
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_found     = out_found_q;
	assign out_value_out = out_value_q;

endmodule

@@ sim/tb_decimal_trie_lookup_insert_top.sv @@
`timescale 1ns / 100ps

module tb_decimal_trie_lookup_insert_top;

	localparam int TRIE_NODES      = dtli_pkg::NODE_CAP_DEF;
	localparam int TRIE_LEVELS     = dtli_pkg::LEVELS_DEF;
	localparam int RAND_WORDS      = 1000;
	localparam int RSP_HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES    = 40;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int POOL_MAX        = 512;

	localparam bit CMD_SEARCH = 1'b0;
	localparam bit CMD_UPDATE = 1'b1;

	typedef struct packed {
		dtli_pkg::status_t status;
		bit                found;
		bit [31:0]         value_out;
	} trie_result_t;

	typedef struct packed {
		bit           cmd;
		bit [35:0]    key;
		bit [31:0]    val;
		bit           typed;
		trie_result_t res;
	} trie_stim_t;

	localparam int DIR_WORDS = 23;
	localparam trie_stim_t directed_words [DIR_WORDS] = '{
		'{CMD_SEARCH, 36'h000000000, 32'h0,        1'b1, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h999999999, 32'hFFFFFFFF, 1'b1, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h000000000, 32'hFFFFFFFF, 1'b1, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h000000000, 32'h0,        1'b1,
			'{dtli_pkg::STAT_OK, 1'b1, 32'hFFFFFFFF}},
		'{CMD_UPDATE, 36'h999999999, 32'h00000001, 1'b1, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h999999999, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h123456780, 32'hA5A55A5A, 1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h123456781, 32'h5A5AA5A5, 1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h123456781, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h123456780, 32'h00000001, 1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h123456780, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h123456781, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h123456781, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h555555555, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h555555555, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h123000000, 32'h80000000, 1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h12345678A, 32'h0,        1'b1,
			'{dtli_pkg::STAT_BADKEY, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'hF00000000, 32'h000000FF, 1'b1,
			'{dtli_pkg::STAT_BADKEY, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h0000A0000, 32'h12345678, 1'b1,
			'{dtli_pkg::STAT_BADKEY, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'hFFFFFFFFF, 32'h0,        1'b1,
			'{dtli_pkg::STAT_BADKEY, 1'b0, 32'h0}},
		'{CMD_SEARCH, 36'h123456789, 32'h0,        1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}},
		'{CMD_UPDATE, 36'h000000000, 32'h0,        1'b1, '{dtli_pkg::STAT_OK, 1'b1, 32'h0}},
		'{CMD_SEARCH, 36'h000000000, 32'h0,        1'b1, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}}
	};

	logic clk;
	logic arst_n;

	dtli_req_if req_ch();
	dtli_rsp_if rsp_ch();

	decimal_trie_lookup_insert_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bit [31:0]    trie_slots [TRIE_NODES*dtli_pkg::FANOUT];
	int unsigned  next_node = dtli_pkg::ROOTS;
	trie_result_t pending_results [$];
	bit [35:0]    stored_keys [$];

	int cycle_count;
	int fail_count;
	int word_count;
	int hit_count;
	int miss_count;
	int update_count;
	int full_count;
	int badkey_count;
	bit steady_run;
	bit rsp_hold_req;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[decimal_trie_lookup_insert_top] ERROR");
			$finish;
		end
	end

	function automatic trie_result_t trie_apply(input bit upd, input bit [35:0] key,
		input bit [31:0] val);
		trie_result_t res;
		int unsigned  dig [dtli_pkg::KEY_DIGITS];
		int unsigned  node;
		int unsigned  d;
		int unsigned  need;
		int unsigned  fresh;
		bit [31:0]    s;

		res = '{dtli_pkg::STAT_OK, 1'b0, 32'h0};
		for (int i = 0; i <= TRIE_LEVELS; i++) begin
			dig[i] = 32'(key[4*(TRIE_LEVELS-i) +: 4]);
			if (dig[i] > 9) begin
				res.status = dtli_pkg::STAT_BADKEY;
				return res;
			end
		end
		node = dig[0];
		for (int i = 0; i < TRIE_LEVELS; i++) begin
			d = dig[i+1];
			s = trie_slots[node*dtli_pkg::FANOUT + d];
			if (i == TRIE_LEVELS - 1) begin
				if (!upd) begin
					if (s != 0) begin
						res.found = 1'b1;
						res.value_out = s;
					end
				end else begin
					res.found = (s != 0);
					trie_slots[node*dtli_pkg::FANOUT + d] = val;
				end
				return res;
			end
			if (s == 0 || s >= TRIE_NODES) begin
				need = TRIE_LEVELS - 1 - i;
				if (!upd)
					return res;
				if (next_node + need > TRIE_NODES) begin
					res.status = dtli_pkg::STAT_FULL;
					return res;
				end
				trie_slots[node*dtli_pkg::FANOUT + d] = next_node;
				for (int k = 0; k < need; k++) begin
					fresh = next_node + k;
					for (int j = 0; j < dtli_pkg::FANOUT; j++)
						trie_slots[fresh*dtli_pkg::FANOUT + j] = '0;
					if (k == need - 1)
						trie_slots[fresh*dtli_pkg::FANOUT + dig[i+2+k]] = val;
					else
						trie_slots[fresh*dtli_pkg::FANOUT + dig[i+2+k]] = fresh + 1;
				end
				next_node += need;
				return res;
			end
			node = s;
		end
		return res;
	endfunction

	function automatic bit take_break();
		return !steady_run && ($urandom_range(99) < 14);
	endfunction

	function automatic bit [35:0] random_key();
		bit [35:0] k;

		for (int i = 0; i < dtli_pkg::KEY_DIGITS; i++)
			k[4*i +: 4] = 4'($urandom_range(9));
		return k;
	endfunction

	function automatic bit [35:0] neighbor_key(input bit [35:0] base);
		bit [35:0] k;
		int        n;

		k = base;
		n = $urandom_range(TRIE_LEVELS, 1);
		for (int i = 0; i < n; i++)
			k[4*i +: 4] = 4'($urandom_range(9));
		return k;
	endfunction

	function automatic bit [31:0] random_value();
		case ($urandom_range(15))
			0: return 32'hFFFFFFFF;
			1: return 32'h00000001;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [35:0] pool_key();
		return stored_keys[$urandom_range(stored_keys.size() - 1)];
	endfunction

	function automatic void remember_key(input bit [35:0] k);
		if (stored_keys.size() < POOL_MAX)
			stored_keys.push_back(k);
		else
			stored_keys[$urandom_range(POOL_MAX - 1)] = k;
	endfunction

	task automatic send_word(input trie_stim_t w);
		trie_result_t res;
		int           gap;

		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.command    <= w.cmd;
		req_ch.key_digits <= w.key;
		req_ch.value      <= w.val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		res = trie_apply(w.cmd, w.key, w.val);
		word_count++;
		if (res.status == dtli_pkg::STAT_BADKEY)
			badkey_count++;
		else if (res.status == dtli_pkg::STAT_FULL)
			full_count++;
		else if (w.cmd == CMD_UPDATE)
			update_count++;
		else if (res.found)
			hit_count++;
		else
			miss_count++;
		pending_results.push_back(w.typed ? w.res : res);
		if (take_break()) begin
			gap = $urandom_range(6, 1);
			repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
		end
	endtask

	// result check
	always @(posedge clk) begin
		trie_result_t want;

		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word status %0d found %0d value %h", $time,
					rsp_ch.status, rsp_ch.found, rsp_ch.value_out);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found,
						rsp_ch.found);
					fail_count++;
				end
				if (rsp_ch.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h actual %h", $time,
						want.value_out, rsp_ch.value_out);
					fail_count++;
				end
			end
		end
	end

	// receiver, with one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES - 1) @(negedge clk) rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !take_break();
			end
		end
	end

	initial begin
		trie_stim_t w;
		int         rand_words;
		int         pick;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.command    = CMD_SEARCH;
		req_ch.key_digits = '0;
		req_ch.value      = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_WORDS; i++)
			send_word(directed_words[i]);

		rand_words = 0;
		while (rand_words < RAND_WORDS) begin
			steady_run = (rand_words >= 200 && rand_words < 400);
			if (rand_words == 600)
				rsp_hold_req = 1'b1;
			w = '{CMD_SEARCH, 36'h0, 32'h0, 1'b0, '{dtli_pkg::STAT_OK, 1'b0, 32'h0}};
			pick = $urandom_range(99);
			if (stored_keys.size() == 0)
				pick = 0;
			if (pick < 45) begin
				w.cmd = CMD_UPDATE;
				w.key = random_key();
				w.val = ($urandom_range(9) == 0) ? 32'h0 : random_value();
				remember_key(w.key);
			end else if (pick < 60) begin
				w.cmd = CMD_UPDATE;
				w.key = neighbor_key(pool_key());
				w.val = random_value();
				remember_key(w.key);
			end else if (pick < 75) begin
				w.key = pool_key();
				w.val = $urandom;
			end else if (pick < 82) begin
				w.cmd = CMD_UPDATE;
				w.key = pool_key();
				w.val = random_value();
			end else if (pick < 86) begin
				w.cmd = CMD_UPDATE;
				w.key = pool_key();
			end else if (pick < 90) begin
				w.key = random_key();
			end else if (pick < 94) begin
				w.key = neighbor_key(pool_key());
			end else begin
				w.cmd = 1'($urandom_range(1));
				w.key = random_key();
				w.key[4*$urandom_range(TRIE_LEVELS) +: 4] = 4'($urandom_range(15, 10));
				if ($urandom_range(3) == 0)
					w.key = 36'({$urandom, $urandom});
				w.val = $urandom;
			end
			send_word(w);
			rand_words++;
		end
		steady_run = 1'b0;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words: %0d hits, %0d misses, %0d updates, %0d store full, %0d bad keys",
			word_count, hit_count, miss_count, update_count, full_count, badkey_count);
		$display("%0d of %0d trie nodes allocated, %0d mismatches", next_node, TRIE_NODES,
			fail_count);
		if (fail_count == 0)
			$display("[decimal_trie_lookup_insert_top] OK");
		else
			$display("[decimal_trie_lookup_insert_top] ERROR");
		$finish;
	end

endmodule

@@ decimal_trie_lookup_insert_top.f @@
design/dtli_pkg.sv
design/dtli_req_if.sv
design/dtli_rsp_if.sv
design/dtli_ctrl.sv
design/dtli_dp.sv
design/decimal_trie_lookup_insert_top.sv
sim/tb_decimal_trie_lookup_insert_top.sv
